// ===== rtl/core/s256sb_pkg.sv =====
// shared types, constants and round functions for the sha-256 single block hasher
// no dependencies; imported by every module under rtl/core
`timescale 1ns / 1ps

package s256sb_pkg;

  localparam int WORD_W = 32;
  localparam int WORDS_PER_BLOCK = 16;
  localparam int ROUNDS = 64;
  localparam int NUM_VARS = 8;
  localparam int WCNT_W = $clog2(WORDS_PER_BLOCK);
  localparam int RCNT_W = $clog2(ROUNDS);
  localparam logic [WCNT_W-1:0] WORD_LAST = WCNT_W'(WORDS_PER_BLOCK - 1);
  localparam logic [RCNT_W-1:0] ROUND_LAST = RCNT_W'(ROUNDS - 1);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [NUM_VARS-1:0][WORD_W-1:0] vars_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ROUND,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_iv;
    logic step;
  } rnd_ctl_t;

  localparam word_t IV [NUM_VARS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t K_TABLE [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(word_t v, int amt);
    rotr = (v >> amt) | (v << (WORD_W - amt));
  endfunction

  function automatic word_t ssig0(word_t x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(word_t x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(word_t x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(word_t x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t choose(word_t e, word_t f, word_t g);
    choose = (e & f) ^ (~e & g);
  endfunction

  function automatic word_t majority(word_t a, word_t b, word_t c);
    majority = (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

// ===== rtl/core/s256sb_wcell.sv =====
// one cell of the message schedule chain: a 32-bit word that takes its neighbor's word
// depends on s256sb_pkg
`timescale 1ns / 1ps

module s256sb_wcell (
  input  logic                clk,
  input  logic                shift,
  input  s256sb_pkg::word_t   d,
  output s256sb_pkg::word_t   q
);
  import s256sb_pkg::*;

  word_t data;

  always_ff @(posedge clk) begin
    if (shift) begin
      data <= d;
    end
  end

  assign q = data;

endmodule

// ===== rtl/core/s256sb_round.sv =====
// sha-256 working variables a..h and the compression round, one round per step
// depends on s256sb_pkg
`timescale 1ns / 1ps

module s256sb_round (
  input  logic                 clk,
  input  s256sb_pkg::rnd_ctl_t ctl,
  input  s256sb_pkg::word_t    k,
  input  s256sb_pkg::word_t    w,
  output s256sb_pkg::vars_t    vars
);
  import s256sb_pkg::*;

  vars_t v;
  vars_t v_next;
  word_t t1;
  word_t t2;

  // index 0 is a, index 7 is h
  always_comb begin
    t1 = v[7] + bsig1(v[4]) + choose(v[4], v[5], v[6]) + k + w;
    t2 = bsig0(v[0]) + majority(v[0], v[1], v[2]);
    v_next = v;
    if (ctl.load_iv) begin
      for (int i = 0; i < NUM_VARS; i++) begin
        v_next[i] = IV[i];
      end
    end else if (ctl.step) begin
      v_next[0] = t1 + t2;
      v_next[1] = v[0];
      v_next[2] = v[1];
      v_next[3] = v[2];
      v_next[4] = v[3] + t1;
      v_next[5] = v[4];
      v_next[6] = v[5];
      v_next[7] = v[6];
    end
  end

  always_ff @(posedge clk) begin
    v <= v_next;
  end

  assign vars = v;

endmodule

// ===== rtl/core/sha256_single_block_hash.sv =====
// sha-256 single block hasher top level: word intake, schedule cell chain, round control
// depends on s256sb_pkg, s256sb_wcell, s256sb_round
`timescale 1ns / 1ps

// channel  dir  tdata bits  fields (low bit up)
// s_*      in   32          message_word
// m_*      out  256         digest_0, digest_1, digest_2, digest_3
//
// sixteen words are taken one per cycle while s_tvalid is high, then 64 rounds (one
// round per cycle through the round unit) and the final add into the output register.
// words of the next block are taken while a digest waits in the output register;
// the final add waits until that register is free.
// rst drops a partly loaded block and empties the output register.

module sha256_single_block_hash (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // message_word
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [255:0] m_tdata    // digest_0, digest_1, digest_2, digest_3
);
  import s256sb_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [WCNT_W-1:0] word_cnt;
  logic [RCNT_W-1:0] round_cnt;
  rnd_ctl_t          ctl;
  logic              win_shift;
  logic              out_load;
  word_t             win [WORDS_PER_BLOCK];
  word_t             win_in;
  word_t             expand;
  vars_t             vars;
  logic [255:0]      digest;

  // schedule chain: cell 0 holds w[t] during round t, new words enter at the top
  for (genvar i = 0; i < WORDS_PER_BLOCK; i++) begin : g_win
    if (i == WORDS_PER_BLOCK - 1) begin : g_top
      s256sb_wcell u_cell (.clk(clk), .shift(win_shift), .d(win_in), .q(win[i]));
    end else begin : g_mid
      s256sb_wcell u_cell (.clk(clk), .shift(win_shift), .d(win[i+1]), .q(win[i]));
    end
  end

  assign expand = ssig1(win[14]) + win[9] + ssig0(win[1]) + win[0];
  assign win_in = (state == ST_ROUND) ? expand : s_tdata;

  s256sb_round u_round (
    .clk  (clk),
    .ctl  (ctl),
    .k    (K_TABLE[round_cnt]),
    .w    (win[0]),
    .vars (vars)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    ctl        = '0;
    win_shift  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_LOAD: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          win_shift = 1'b1;
          if (word_cnt == WORD_LAST) begin
            ctl.load_iv = 1'b1;
            state_next  = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        ctl.step  = 1'b1;
        win_shift = 1'b1;
        if (round_cnt == ROUND_LAST) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_cnt  <= '0;
      round_cnt <= '0;
    end else begin
      if (state == ST_LOAD && s_tvalid) begin
        word_cnt <= word_cnt + 1'b1;
      end
      if (state == ST_ROUND) begin
        round_cnt <= round_cnt + 1'b1;
      end else begin
        round_cnt <= '0;
      end
    end
  end

  // final add of the initial hash; digest_j = {H[2j], H[2j+1]}
  always_comb begin
    for (int j = 0; j < NUM_VARS / 2; j++) begin
      digest[64*j+32 +: 32] = vars[2*j] + IV[2*j];
      digest[64*j    +: 32] = vars[2*j+1] + IV[2*j+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= digest;
    end
  end

`ifndef SYNTHESIS
  a_last_word_starts_rounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD && s_tvalid && word_cnt == WORD_LAST)
      |=> (state == ST_ROUND && round_cnt == '0))
    else $error("last word did not start the rounds");

  a_rounds_end_in_finish: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && round_cnt == ROUND_LAST) |=> state == ST_FINISH)
    else $error("round sequence did not end after the last round");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_FINISH)
    else $error("result appeared outside the final add");

  a_no_intake_in_rounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) |=> $stable(word_cnt))
    else $error("word count moved during rounds");
`endif

endmodule
